// ===== sv/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

    localparam int unsigned FifoDepth = 4;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    typedef enum logic {
        REQ_DATA     = 1'b0,
        REQ_FINALIZE = 1'b1
    } req_kind_t;

    typedef enum logic [2:0] {
        ST_FILL,
        ST_COMP,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } core_state_t;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_stream_hasher_core.sv =====
// Top level of the SHA-256 stream hasher: input queue front end and hashing back end.
// Items enter a four-entry queue at one per cycle while it has room; the back end
// takes one byte per cycle into the block while the queue holds items, then runs 64
// compression rounds on one shared round unit and takes no input while it does so.
// Finalize adds padding at one byte per cycle, one or two compressions, then eight
// digest items, one per cycle while out_ready.
module sha256_stream_hasher_core
    import sha256_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FifoDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);
    logic     q_full, q_empty, q_pop;
    in_item_t q_item;

    assign in_ready = !q_full;

    sha256_in_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid),
        .push_item(in_data),
        .full     (q_full),
        .pop      (q_pop),
        .pop_item (q_item),
        .empty    (q_empty)
    );

    sha256_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(!q_empty),
        .item      (q_item),
        .item_pop  (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );
endmodule

// ===== sv/sha256_in_fifo.sv =====
// Short input queue between the input port and the hashing back end.
module sha256_in_fifo
    import sha256_pkg::*;
#(
    parameter int unsigned DEPTH = FifoDepth
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  in_item_t push_item,
    output logic     full,
    input  logic     pop,
    output in_item_t pop_item,
    output logic     empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    in_item_t          mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]       count_reg;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule

// ===== sv/sha256_round.sv =====
// Iterative SHA-256 compression: one round per cycle with a rolling message schedule.
module sha256_round
    import sha256_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [511:0] block,
    input  logic [255:0] chain_in,
    output logic         busy,
    output logic         done,
    output logic [255:0] chain_out
);
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [5:0]  t_reg;
    logic        busy_reg, done_reg;

    logic [31:0] wt, wnew, s0, s1, big0, big1, ch, maj, t1, t2;

    always_comb
    begin
        wt   = w_reg[0];
        s0   = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1   = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wnew = s1 + w_reg[9] + s0 + w_reg[0];
        big1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        big0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1   = v_reg[7] + big1 + ch + round_k(t_reg) + wt;
        t2   = big0 + maj;
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chain_out[255 - 32*i -: 32] = h_reg[i];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= chain_in[255 - 32*i -: 32];
                h_reg[i] <= chain_in[255 - 32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else if (done_reg)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    // done pulses in the cycle after the last round; chain_out is valid the cycle after done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                t_reg    <= '0;
            end
            else if (busy_reg)
            begin
                t_reg <= t_reg + 1'b1;
                if (t_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== sv/sha256_engine.sv =====
// Back end: packs bytes into blocks, pads on finalize, runs compressions, emits digest.
module sha256_engine
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  in_item_t  item,
    output logic      item_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);
    core_state_t  state_reg, state_next;
    logic [511:0] blk_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  count_reg;
    logic [255:0] chain_reg;
    logic [2:0]   idx_reg;
    logic         final_reg;   // finalize pending on current compression
    logic         len_reg;     // current compression holds the length
    logic         waitc_reg;   // waiting for the round unit's chain add

    logic         c_start, c_busy, c_done;
    logic [255:0] c_out;
    logic [63:0]  bits;

    assign bits = {count_reg, 3'b000};

    sha256_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (c_start),
        .block    (blk_reg),
        .chain_in (chain_reg),
        .busy     (c_busy),
        .done     (c_done),
        .chain_out(c_out)
    );

    always_comb
    begin
        state_next = state_reg;
        item_pop   = 1'b0;
        c_start    = 1'b0;
        out_valid  = 1'b0;
        out_item.digest_word = chain_reg[255 - 32*idx_reg -: 32];
        out_item.word_index  = idx_reg;
        out_item.last_word   = (idx_reg == 3'd7);
        case (state_reg)
            ST_FILL:
            begin
                item_pop = item_valid;
                if (item_valid)
                begin
                    if (item.req_type == REQ_FINALIZE)
                    begin
                        state_next = (fill_reg == LenPos - 1'b1) ? ST_LEN : ST_PAD;
                        if (fill_reg == 6'd63)
                        begin
                            state_next = ST_COMP;
                            c_start    = 1'b0;
                        end
                    end
                    else if (fill_reg == 6'd63)
                    begin
                        state_next = ST_COMP;
                    end
                end
            end
            ST_PAD:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_COMP;
                end
                else if (fill_reg == LenPos - 1'b1)
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                c_start = !c_busy && !c_done && !waitc_reg;
                if (waitc_reg)
                begin
                    if (len_reg)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (final_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready && idx_reg == 3'd7)
                begin
                    state_next = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg  <= '0;
            count_reg <= '0;
            chain_reg <= InitHash;
            idx_reg   <= '0;
            final_reg <= 1'b0;
            len_reg   <= 1'b0;
            waitc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_FILL:
                begin
                    if (item_valid)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                        if (item.req_type == REQ_FINALIZE)
                        begin
                            final_reg <= 1'b1;
                            // 0x80 may itself fill the block; length then needs a new block
                            len_reg   <= (fill_reg == LenPos - 1'b1) ? 1'b0 : 1'b0;
                        end
                        else
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                ST_LEN:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    if (fill_reg == 6'd63)
                    begin
                        len_reg <= 1'b1;
                    end
                end
                ST_COMP:
                begin
                    if (c_done)
                    begin
                        waitc_reg <= 1'b1;
                    end
                    if (waitc_reg)
                    begin
                        waitc_reg <= 1'b0;
                        chain_reg <= c_out;
                        idx_reg   <= '0;
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7)
                        begin
                            chain_reg <= InitHash;
                            count_reg <= '0;
                            fill_reg  <= '0;
                            final_reg <= 1'b0;
                            len_reg   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // block buffer shifts in one byte per cycle (in fill only while an item is valid): data byte,
    // pad 0x80, zero fill or length byte; after 64 bytes the first one sits in the top byte
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_FILL:
            begin
                if (item_valid)
                begin
                    blk_reg <= {blk_reg[503:0],
                        ((item.req_type == REQ_FINALIZE) ? PadByte : item.data_byte)};
                end
            end
            ST_PAD:
            begin
                blk_reg <= {blk_reg[503:0], 8'h00};
            end
            ST_LEN:
            begin
                blk_reg <= {blk_reg[503:0], bits[63 - 8*fill_reg[2:0] -: 8]};
            end
            default: ;
        endcase
    end
endmodule
